// ===== rtl/core/rate_monotonic_run_queue_assert.svh =====
// Assertion macros shared by the run queue RTL.
`ifndef RATE_MONOTONIC_RUN_QUEUE_ASSERT_SVH
`define RATE_MONOTONIC_RUN_QUEUE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define RMRQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define RMRQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rmrq_pkg.sv =====
// Package with the types and constants of the rate-monotonic run queue.
package rmrq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;
	localparam int PERIOD_W        = 16;
	localparam int REQ_W           = 3;
	localparam int STATUS_W        = 2;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_ENQ   = 3'd0,
		REQ_DEQ   = 3'd1,
		REQ_YIELD = 3'd2,
		REQ_TICK  = 3'd3,
		REQ_PICK  = 3'd4
	} req_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_NOTQ  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// Per-cell load controls from the sequencer.
	typedef struct packed {
		logic load;
		logic take_ins;
	} cell_ctl_t;

endpackage

// ===== rtl/core/rmrq_cell.sv =====
// One queue cell: holds a task entry and loads from its right neighbor or the insert bus.
module rmrq_cell #(
	parameter int ID_BITS = rmrq_pkg::ID_BITS_DEF
) (
	input  logic                          clk,
	input  rmrq_pkg::cell_ctl_t           ctl,
	input  logic [ID_BITS-1:0]            nbr_id,
	input  logic [rmrq_pkg::PERIOD_W-1:0] nbr_period,
	input  logic [rmrq_pkg::PERIOD_W-1:0] nbr_rem,
	input  logic [ID_BITS-1:0]            ins_id,
	input  logic [rmrq_pkg::PERIOD_W-1:0] ins_period,
	input  logic [rmrq_pkg::PERIOD_W-1:0] ins_rem,
	output logic [ID_BITS-1:0]            id,
	output logic [rmrq_pkg::PERIOD_W-1:0] period,
	output logic [rmrq_pkg::PERIOD_W-1:0] rem
);
	import rmrq_pkg::*;

	logic [ID_BITS-1:0]  id_q;
	logic [PERIOD_W-1:0] period_q;
	logic [PERIOD_W-1:0] rem_q;

	// Entry storage; the contents are meaningful only below the queue occupancy.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			if (ctl.take_ins) begin
				id_q     <= ins_id;
				period_q <= ins_period;
				rem_q    <= ins_rem;
			end else begin
				id_q     <= nbr_id;
				period_q <= nbr_period;
				rem_q    <= nbr_rem;
			end
		end
	end

	assign id     = id_q;
	assign period = period_q;
	assign rem    = rem_q;

endmodule

// ===== rtl/core/rate_monotonic_run_queue.sv =====
// Top level of the rate-monotonic run queue: cell chain and request sequencer.
//
// A request is taken when start is high and busy is low, and its result appears
// on the result ports for exactly one cycle with done high; the receiver cannot
// stall it, so it must capture the result in that cycle. Every known request
// rotates the whole queue once past the head cell, one entry per cycle, to look
// up the named task, drop it or update it, and track the shortest period, then
// appends at the tail and forms the result; request codes five to seven, and
// requests that find the queue empty, skip the rotation.
// The queue is empty after reset and needs no initialization.
module rate_monotonic_run_queue #(
	parameter  int QUEUE_DEPTH = rmrq_pkg::QUEUE_DEPTH_DEF,
	parameter  int ID_BITS     = rmrq_pkg::ID_BITS_DEF,
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [rmrq_pkg::REQ_W-1:0]    req_type,
	input  logic [ID_BITS-1:0]            task_id,
	input  logic [rmrq_pkg::PERIOD_W-1:0] period_ticks,
	output logic                          done,
	output logic [ID_BITS-1:0]            chosen_task,
	output logic                          chosen_valid,
	output logic                          resched,
	output logic [rmrq_pkg::STATUS_W-1:0] status,
	output logic [CNT_W-1:0]              queued_count
);
	import rmrq_pkg::*;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_APPEND
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [ID_BITS-1:0]  id_q;
	logic [PERIOD_W-1:0] period_q;
	logic [CNT_W-1:0]    occ_q;
	logic [CNT_W-1:0]    steps_q;
	logic                found_q;
	logic                hold_v_q;
	logic [ID_BITS-1:0]  hold_id_q;
	logic [PERIOD_W-1:0] hold_period_q;
	logic [PERIOD_W-1:0] hold_rem_q;
	logic                best_v_q;
	logic [ID_BITS-1:0]  best_id_q;
	logic [PERIOD_W-1:0] best_period_q;
	logic                resched_flag_q;

	logic                done_q;
	logic [ID_BITS-1:0]  chosen_task_q;
	logic                chosen_valid_q;
	logic                resched_q;
	status_t             status_q;
	logic [CNT_W-1:0]    queued_count_q;

	logic [ID_BITS-1:0]  cell_id     [QUEUE_DEPTH];
	logic [PERIOD_W-1:0] cell_period [QUEUE_DEPTH];
	logic [PERIOD_W-1:0] cell_rem    [QUEUE_DEPTH];
	cell_ctl_t           cell_ctl    [QUEUE_DEPTH];

	logic [ID_BITS-1:0]  ins_id;
	logic [PERIOD_W-1:0] ins_period;
	logic [PERIOD_W-1:0] ins_rem;

	logic                shift;
	logic                is_named;
	logic                match;
	logic [PERIOD_W-1:0] tick_rem;
	logic                remove;
	logic [PERIOD_W-1:0] keep_rem;
	logic                append;
	logic [CNT_W-1:0]    tail;
	logic                req_known;
	logic [PERIOD_W-1:0] start_period;

	// Head-cell examination during the rotation.
	assign shift    = (state_q == S_SCAN);
	assign is_named = (req_q == REQ_ENQ) || (req_q == REQ_DEQ) ||
		(req_q == REQ_YIELD) || (req_q == REQ_TICK);
	assign match    = shift && is_named && !found_q && (cell_id[0] == id_q);
	assign tick_rem = (cell_rem[0] <= PERIOD_W'(1)) ? '0 : cell_rem[0] - PERIOD_W'(1);
	assign remove   = match && ((req_q != REQ_TICK) || (tick_rem == '0));
	assign keep_rem = (match && (req_q == REQ_TICK)) ? tick_rem : cell_rem[0];
	assign tail     = occ_q - CNT_W'(1);

	// Tail append: a held entry, or a new task when the queue has room.
	assign append = (state_q == S_APPEND) &&
		(hold_v_q || ((req_q == REQ_ENQ) && !found_q && (occ_q != FULL_CNT)));

	// Insert bus: the rotated head entry while scanning, the appended entry after.
	always_comb begin
		if (shift) begin
			ins_id     = cell_id[0];
			ins_period = cell_period[0];
			ins_rem    = keep_rem;
		end else if (hold_v_q) begin
			ins_id     = hold_id_q;
			ins_period = hold_period_q;
			ins_rem    = hold_rem_q;
		end else begin
			ins_id     = id_q;
			ins_period = period_q;
			ins_rem    = period_q;
		end
	end

	// Chain of cells; on a shift each cell below the tail takes its right neighbor's entry, the tail cell the insert bus.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [ID_BITS-1:0]  nbr_id;
		logic [PERIOD_W-1:0] nbr_period;
		logic [PERIOD_W-1:0] nbr_rem;

		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nbr_id     = ins_id;
			assign nbr_period = ins_period;
			assign nbr_rem    = ins_rem;
		end else begin : g_mid
			assign nbr_id     = cell_id[i+1];
			assign nbr_period = cell_period[i+1];
			assign nbr_rem    = cell_rem[i+1];
		end

		assign cell_ctl[i].load =
			(shift && ((CNT_W'(i) < tail) || ((CNT_W'(i) == tail) && !remove))) ||
			(append && (CNT_W'(i) == occ_q));
		assign cell_ctl[i].take_ins = shift ? (CNT_W'(i) == tail) : 1'b1;

		rmrq_cell #(
			.ID_BITS(ID_BITS)
		) u_cell (
			.clk       (clk),
			.ctl       (cell_ctl[i]),
			.nbr_id    (nbr_id),
			.nbr_period(nbr_period),
			.nbr_rem   (nbr_rem),
			.ins_id    (ins_id),
			.ins_period(ins_period),
			.ins_rem   (ins_rem),
			.id        (cell_id[i]),
			.period    (cell_period[i]),
			.rem       (cell_rem[i])
		);
	end

	// Request decode at acceptance.
	assign req_known    = (req_type <= REQ_W'(REQ_PICK));
	assign start_period = (period_ticks == '0) ? PERIOD_W'(1) : period_ticks;

	// Sequencer state and registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			req_q          <= REQ_ENQ;
			id_q           <= '0;
			period_q       <= '0;
			occ_q          <= '0;
			steps_q        <= '0;
			found_q        <= 1'b0;
			hold_v_q       <= 1'b0;
			hold_id_q      <= '0;
			hold_period_q  <= '0;
			hold_rem_q     <= '0;
			best_v_q       <= 1'b0;
			best_id_q      <= '0;
			best_period_q  <= '0;
			resched_flag_q <= 1'b0;
			done_q         <= 1'b0;
			chosen_task_q  <= '0;
			chosen_valid_q <= 1'b0;
			resched_q      <= 1'b0;
			status_q       <= ST_OK;
			queued_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q          <= req_t'(req_type);
						id_q           <= task_id;
						period_q       <= start_period;
						found_q        <= 1'b0;
						hold_v_q       <= 1'b0;
						best_v_q       <= 1'b0;
						resched_flag_q <= 1'b0;
						steps_q        <= req_known ? occ_q : '0;
						state_q        <= (req_known && (occ_q != '0)) ? S_SCAN : S_APPEND;
					end
				end
				S_SCAN: begin
					// Shortest period so far; strict compare keeps the earliest on ties.
					if ((req_q == REQ_PICK) && (!best_v_q || (cell_period[0] < best_period_q)))
					begin
						best_v_q      <= 1'b1;
						best_id_q     <= cell_id[0];
						best_period_q <= cell_period[0];
					end
					// The named task: hold it aside when it is going to the tail.
					if (match) begin
						found_q <= 1'b1;
						unique case (req_q)
							REQ_ENQ: begin
								hold_v_q      <= 1'b1;
								hold_id_q     <= id_q;
								hold_period_q <= period_q;
								hold_rem_q    <= period_q;
							end
							REQ_YIELD: begin
								hold_v_q      <= 1'b1;
								hold_id_q     <= cell_id[0];
								hold_period_q <= cell_period[0];
								hold_rem_q    <= cell_rem[0];
							end
							REQ_TICK: begin
								if (tick_rem == '0) begin
									hold_v_q       <= 1'b1;
									hold_id_q      <= cell_id[0];
									hold_period_q  <= cell_period[0];
									hold_rem_q     <= cell_period[0];
									resched_flag_q <= 1'b1;
								end
							end
							default: begin
							end
						endcase
					end
					if (remove) begin
						occ_q <= occ_q - CNT_W'(1);
					end
					steps_q <= steps_q - CNT_W'(1);
					if (steps_q == CNT_W'(1)) begin
						state_q <= S_APPEND;
					end
				end
				S_APPEND: begin
					if (append) begin
						occ_q <= occ_q + CNT_W'(1);
					end
					unique case (req_q) inside
						REQ_ENQ: begin
							status_q <= (!found_q && (occ_q == FULL_CNT)) ? ST_FULL : ST_OK;
						end
						REQ_DEQ, REQ_YIELD, REQ_TICK: begin
							status_q <= found_q ? ST_OK : ST_NOTQ;
						end
						REQ_PICK: begin
							status_q <= best_v_q ? ST_OK : ST_EMPTY;
						end
						default: begin
							status_q <= ST_OK;
						end
					endcase
					chosen_valid_q <= (req_q == REQ_PICK) && best_v_q;
					chosen_task_q  <= ((req_q == REQ_PICK) && best_v_q) ? best_id_q : '0;
					resched_q      <= resched_flag_q;
					queued_count_q <= append ? (occ_q + CNT_W'(1)) : occ_q;
					done_q         <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign chosen_task  = chosen_task_q;
	assign chosen_valid = chosen_valid_q;
	assign resched      = resched_q;
	assign status       = status_q;
	assign queued_count = queued_count_q;

	// Checks on the sequencer and the result it forms.
`include "rate_monotonic_run_queue_assert.svh"

	`RMRQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done,
		"accepted request neither busy nor done next cycle")
	`RMRQ_ASSERT_ALWAYS(a_count_bound, occ_q <= FULL_CNT, "occupancy above queue depth")
	`RMRQ_ASSERT_ALWAYS(a_pick_resched, !(done && chosen_valid && resched),
		"pick result and reschedule raised together")
	`RMRQ_ASSERT_NEXT(a_remove_named, remove, found_q,
		"entry removed without the named task being found")

endmodule
